>>> hdl/plate_hash_table_quadratic_probe_defines.svh
// Assertion macros of the plate hash table RTL, used by phtqp_back.
// Expects clk and rst_n in the scope of the module that uses them.
`ifndef PLATE_HASH_TABLE_QUADRATIC_PROBE_DEFINES_SVH
`define PLATE_HASH_TABLE_QUADRATIC_PROBE_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, checked on every rising edge out of reset.
`define PHTQP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked on every rising edge out of reset.
`define PHTQP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PHTQP_ASSERT_IMP(lbl, ante, cons, msg)
`define PHTQP_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

>>> hdl/phtqp_pkg.sv
// Shared types and constants of the plate hash table.
// No dependencies; used by every module of the block.
package phtqp_pkg;

    // Field widths of the request and response items.
    localparam int FUNC_W   = 2;
    localparam int PLATE_W  = 64;
    localparam int SLOT_W   = 11;
    localparam int STATUS_W = 2;
    localparam int COLL_W   = 11;

    // Home slot arithmetic: letter weights, digit weights and partial widths.
    localparam int LET_W  = 23;
    localparam int NUM_W  = 19;
    localparam int SUM_W  = 36;
    localparam int W_L0   = 17576;
    localparam int W_L1   = 676;
    localparam int W_L2   = 26;
    localparam int W_D0   = 1000;
    localparam int W_D1   = 100;
    localparam int W_D2   = 10;
    localparam int LETTER_SCALE = 10000;

    // Residue unit consumes this many sum bits per cycle.
    localparam int DIG_W     = 6;
    localparam int MOD_STEPS = SUM_W / DIG_W;

    typedef enum logic [FUNC_W-1:0] {
        FN_INSERT = 2'd0,
        FN_SEARCH = 2'd1,
        FN_REMOVE = 2'd2
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE   = 2'd0,
        ST_ABSENT = 2'd1,
        ST_FULL   = 2'd2
    } status_t;

    // One request as it travels from the front end to the probe engine.
    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [PLATE_W-1:0] plate;
    } req_t;

    // Occupancy flags of the hand-off queue.
    typedef struct packed {
        logic full;
        logic empty;
    } q_flags_t;

endpackage

>>> hdl/phtqp_front.sv
// Front end of the plate hash table: accepts requests and computes the home slot.
// Depends on phtqp_pkg; feeds phtqp_queue.
module phtqp_front #(
    parameter int TABLE_SIZE = 1031
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    output logic                            req_stall,
    input  logic [phtqp_pkg::FUNC_W-1:0]    func,
    input  logic [phtqp_pkg::PLATE_W-1:0]   plate,
    input  logic                            clearing,
    input  phtqp_pkg::q_flags_t             q_flags,
    output logic                            q_push,
    output phtqp_pkg::req_t                 q_req,
    output logic [$clog2(TABLE_SIZE)-1:0]   q_home
);

    localparam int IDX_W  = $clog2(TABLE_SIZE);
    localparam int STEP_W = $clog2(phtqp_pkg::MOD_STEPS);
    localparam logic [IDX_W:0] N_EXT = (IDX_W + 1)'(TABLE_SIZE);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(phtqp_pkg::MOD_STEPS - 1);

    typedef enum logic [2:0] {
        F_IDLE,
        F_SUM,
        F_MUL,
        F_MOD,
        F_PUSH
    } fstate_t;

    fstate_t                          state_reg, state_next;
    phtqp_pkg::req_t                  req_reg, req_next;
    logic [phtqp_pkg::LET_W-1:0]      letters_reg, letters_next;
    logic [phtqp_pkg::NUM_W-1:0]      digits_reg, digits_next;
    logic [phtqp_pkg::SUM_W-1:0]      sum_reg, sum_next;
    logic [IDX_W-1:0]                 rem_reg, rem_next;
    logic [STEP_W-1:0]                mstep_reg, mstep_next;
    logic                             accept;
    logic [7:0]                       c0, c1, c2, c3, c4, c5, c6, c7;

    // Folds DIG_W more bits into the running residue, one conditional subtract per bit.
    function automatic logic [IDX_W-1:0] mod_fold(
        input logic [IDX_W-1:0]            r_in,
        input logic [phtqp_pkg::DIG_W-1:0] bits
    );
        logic [IDX_W:0]   acc;
        logic [IDX_W-1:0] r;
        r = r_in;
        for (int i = phtqp_pkg::DIG_W - 1; i >= 0; i--)
        begin
            acc = {r, bits[i]};
            if (acc >= N_EXT)
            begin
                acc = acc - N_EXT;
            end
            r = acc[IDX_W-1:0];
        end
        return r;
    endfunction

    // Plate bytes, first character in the top byte.
    assign c0 = req_reg.plate[63:56];
    assign c1 = req_reg.plate[55:48];
    assign c2 = req_reg.plate[47:40];
    assign c3 = req_reg.plate[39:32];
    assign c4 = req_reg.plate[31:24];
    assign c5 = req_reg.plate[23:16];
    assign c6 = req_reg.plate[15:8];
    assign c7 = req_reg.plate[7:0];

    // A request is taken when idle or as the last one is pushed, not while clearing.
    assign req_stall = clearing ||
                       !((state_reg == F_IDLE) || (state_reg == F_PUSH && !q_flags.full));
    assign accept    = req_valid && !req_stall;

    assign q_push = (state_reg == F_PUSH) && !q_flags.full;
    assign q_req  = req_reg;
    assign q_home = rem_reg;

    // Next-state and datapath logic.
    always_comb
    begin
        state_next   = state_reg;
        req_next     = req_reg;
        letters_next = letters_reg;
        digits_next  = digits_reg;
        sum_next     = sum_reg;
        rem_next     = rem_reg;
        mstep_next   = mstep_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    req_next.func  = func;
                    req_next.plate = plate;
                    state_next     = F_SUM;
                end
            end
            F_SUM:
            begin
                letters_next = phtqp_pkg::LET_W'(c0) * phtqp_pkg::LET_W'(phtqp_pkg::W_L0)
                             + phtqp_pkg::LET_W'(c1) * phtqp_pkg::LET_W'(phtqp_pkg::W_L1)
                             + phtqp_pkg::LET_W'(c2) * phtqp_pkg::LET_W'(phtqp_pkg::W_L2)
                             + phtqp_pkg::LET_W'(c3);
                digits_next  = phtqp_pkg::NUM_W'(c4) * phtqp_pkg::NUM_W'(phtqp_pkg::W_D0)
                             + phtqp_pkg::NUM_W'(c5) * phtqp_pkg::NUM_W'(phtqp_pkg::W_D1)
                             + phtqp_pkg::NUM_W'(c6) * phtqp_pkg::NUM_W'(phtqp_pkg::W_D2)
                             + phtqp_pkg::NUM_W'(c7);
                state_next   = F_MUL;
            end
            F_MUL:
            begin
                sum_next   = phtqp_pkg::SUM_W'(letters_reg)
                           * phtqp_pkg::SUM_W'(phtqp_pkg::LETTER_SCALE)
                           + phtqp_pkg::SUM_W'(digits_reg);
                rem_next   = '0;
                mstep_next = '0;
                state_next = F_MOD;
            end
            F_MOD:
            begin
                rem_next = mod_fold(rem_reg,
                                    sum_reg[phtqp_pkg::SUM_W-1 -: phtqp_pkg::DIG_W]);
                sum_next = {sum_reg[phtqp_pkg::SUM_W-phtqp_pkg::DIG_W-1:0],
                            phtqp_pkg::DIG_W'(0)};
                if (mstep_reg == LAST_STEP)
                begin
                    state_next = F_PUSH;
                end
                else
                begin
                    mstep_next = mstep_reg + STEP_W'(1);
                end
            end
            F_PUSH:
            begin
                if (!q_flags.full)
                begin
                    state_next = F_IDLE;
                    if (accept)
                    begin
                        req_next.func  = func;
                        req_next.plate = plate;
                        state_next     = F_SUM;
                    end
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    // State and working registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= F_IDLE;
            req_reg     <= '0;
            letters_reg <= '0;
            digits_reg  <= '0;
            sum_reg     <= '0;
            rem_reg     <= '0;
            mstep_reg   <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            req_reg     <= req_next;
            letters_reg <= letters_next;
            digits_reg  <= digits_next;
            sum_reg     <= sum_next;
            rem_reg     <= rem_next;
            mstep_reg   <= mstep_next;
        end
    end

endmodule

>>> hdl/phtqp_queue.sv
// Short hand-off queue between the front end and the probe engine.
// Depends on phtqp_pkg for the request type and the flag struct.
module phtqp_queue #(
    parameter int DEPTH  = 2,
    parameter int HOME_W = 11
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  phtqp_pkg::req_t     wr_req,
    input  logic [HOME_W-1:0]   wr_home,
    input  logic                pop,
    output phtqp_pkg::req_t     rd_req,
    output logic [HOME_W-1:0]   rd_home,
    output phtqp_pkg::q_flags_t flags
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    phtqp_pkg::req_t    req_q  [DEPTH];
    logic [HOME_W-1:0]  home_q [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign flags.full  = (count_reg == FULL_CNT);
    assign flags.empty = (count_reg == '0);
    assign do_push     = push && !flags.full;
    assign do_pop      = pop && !flags.empty;
    assign rd_req      = req_q[rd_ptr_reg];
    assign rd_home     = home_q[rd_ptr_reg];

    // Pointer and count update with wrap at the depth.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage; payload only, no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            req_q[wr_ptr_reg]  <= wr_req;
            home_q[wr_ptr_reg] <= wr_home;
        end
    end

endmodule

>>> hdl/phtqp_back.sv
// Probe engine of the plate hash table: owns the slot memories and walks the probe sequence.
// Depends on phtqp_pkg and the assertion macro header; fed by phtqp_queue.
`include "plate_hash_table_quadratic_probe_defines.svh"

module phtqp_back #(
    parameter int TABLE_SIZE = 1031
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  phtqp_pkg::q_flags_t                q_flags,
    input  phtqp_pkg::req_t                    q_req,
    input  logic [$clog2(TABLE_SIZE)-1:0]      q_home,
    output logic                               q_pop,
    output logic                               clearing,
    output logic                               rsp_valid,
    input  logic                               rsp_stall,
    output logic [phtqp_pkg::SLOT_W-1:0]       slot,
    output logic [phtqp_pkg::STATUS_W-1:0]     status,
    output logic [phtqp_pkg::COLL_W-1:0]       collisions
);

    localparam int IDX_W = $clog2(TABLE_SIZE);
    localparam int CNT_W = $clog2(TABLE_SIZE + 1);
    localparam logic [IDX_W:0]   N_EXT    = (IDX_W + 1)'(TABLE_SIZE);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(TABLE_SIZE - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_SIZE);

    typedef enum logic [1:0] {
        B_CLEAR,
        B_IDLE,
        B_PROBE
    } bstate_t;

    // Slot memories and their registered read ports.
    logic [phtqp_pkg::PLATE_W-1:0] plate_mem [TABLE_SIZE];
    logic                          valid_mem [TABLE_SIZE];
    logic [phtqp_pkg::PLATE_W-1:0] rd_plate_reg;
    logic                          rd_valid_reg;

    bstate_t                       state_reg, state_next;
    logic [phtqp_pkg::FUNC_W-1:0]  func_reg, func_next;
    logic [phtqp_pkg::PLATE_W-1:0] plate_reg, plate_next;
    logic [IDX_W-1:0]              idx_reg, idx_next;
    logic [IDX_W-1:0]              step_reg, step_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic [IDX_W-1:0]              clr_reg, clr_next;
    logic                          rsp_valid_reg, rsp_valid_next;
    logic [phtqp_pkg::SLOT_W-1:0]  slot_reg, slot_next;
    phtqp_pkg::status_t            status_reg, status_next;
    logic [phtqp_pkg::COLL_W-1:0]  coll_reg, coll_next;

    logic [IDX_W-1:0]              rd_addr;
    logic                          plate_we;
    logic                          valid_we;
    logic [IDX_W-1:0]              valid_wr_addr;
    logic                          valid_wr_data;

    logic                          out_free;
    logic                          is_insert;
    logic                          is_remove;
    logic                          busy;
    logic                          match;
    logic                          stop_hit;
    logic                          stop_empty;
    logic                          exhausted;
    logic [IDX_W:0]                idx_sum;
    logic [IDX_W:0]                step_sum;
    logic [IDX_W-1:0]              idx_adv;
    logic [IDX_W-1:0]              step_adv;

    assign clearing   = (state_reg == B_CLEAR);
    assign rsp_valid  = rsp_valid_reg;
    assign slot       = slot_reg;
    assign status     = status_reg;
    assign collisions = coll_reg;

    // Probe evaluation against the slot read in the previous cycle.
    assign out_free   = !rsp_valid_reg || !rsp_stall;
    assign is_insert  = (func_reg == phtqp_pkg::FN_INSERT);
    assign is_remove  = (func_reg == phtqp_pkg::FN_REMOVE);
    assign busy       = rd_valid_reg;
    assign match      = busy && (rd_plate_reg == plate_reg);
    assign stop_hit   = is_insert ? (!busy || match) : match;
    assign stop_empty = !is_insert && !busy;
    assign exhausted  = !stop_hit && !stop_empty && (cnt_reg == LAST_CNT);

    // Next quadratic probe: slot advances by 2t+1 and the increment by 2, both mod size.
    assign idx_sum  = {1'b0, idx_reg} + {1'b0, step_reg};
    assign step_sum = {1'b0, step_reg} + (IDX_W + 1)'(2);
    assign idx_adv  = (idx_sum >= N_EXT) ? IDX_W'(idx_sum - N_EXT) : idx_sum[IDX_W-1:0];
    assign step_adv = (step_sum >= N_EXT) ? IDX_W'(step_sum - N_EXT) : step_sum[IDX_W-1:0];

    // Sequencer: clearing pass, request launch, one probe per cycle and a stallable finish.
    always_comb
    begin
        state_next     = state_reg;
        func_next      = func_reg;
        plate_next     = plate_reg;
        idx_next       = idx_reg;
        step_next      = step_reg;
        cnt_next       = cnt_reg;
        clr_next       = clr_reg;
        rsp_valid_next = rsp_valid_reg;
        slot_next      = slot_reg;
        status_next    = status_reg;
        coll_next      = coll_reg;
        rd_addr        = idx_reg;
        plate_we       = 1'b0;
        valid_we       = 1'b0;
        valid_wr_addr  = idx_reg;
        valid_wr_data  = 1'b0;
        q_pop          = 1'b0;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            B_CLEAR:
            begin
                valid_we      = 1'b1;
                valid_wr_addr = clr_reg;
                if (clr_reg == LAST_IDX)
                begin
                    state_next = B_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + IDX_W'(1);
                end
            end
            B_IDLE:
            begin
                rd_addr = q_home;
                if (!q_flags.empty)
                begin
                    q_pop      = 1'b1;
                    func_next  = q_req.func;
                    plate_next = q_req.plate;
                    idx_next   = q_home;
                    step_next  = IDX_W'(1);
                    cnt_next   = '0;
                    state_next = B_PROBE;
                end
            end
            B_PROBE:
            begin
                if (stop_hit || stop_empty || exhausted)
                begin
                    // Finish only when the response register can take the result;
                    // otherwise re-read the same slot and wait.
                    if (out_free)
                    begin
                        rsp_valid_next = 1'b1;
                        state_next     = B_IDLE;
                        if (stop_hit)
                        begin
                            slot_next   = phtqp_pkg::SLOT_W'(idx_reg);
                            status_next = phtqp_pkg::ST_DONE;
                            coll_next   = phtqp_pkg::COLL_W'(cnt_reg);
                            if (is_insert)
                            begin
                                plate_we      = 1'b1;
                                valid_we      = 1'b1;
                                valid_wr_data = 1'b1;
                            end
                            else if (is_remove)
                            begin
                                valid_we      = 1'b1;
                                valid_wr_data = 1'b0;
                            end
                        end
                        else
                        begin
                            slot_next   = '0;
                            status_next = is_insert ? phtqp_pkg::ST_FULL
                                                    : phtqp_pkg::ST_ABSENT;
                            coll_next   = exhausted ? phtqp_pkg::COLL_W'(FULL_CNT)
                                                    : phtqp_pkg::COLL_W'(cnt_reg);
                        end
                    end
                end
                else
                begin
                    // Slot addresses do not depend on the data, so the next read issues now.
                    rd_addr   = idx_adv;
                    idx_next  = idx_adv;
                    step_next = step_adv;
                    cnt_next  = cnt_reg + CNT_W'(1);
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // State and registered response.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_CLEAR;
            func_reg      <= '0;
            plate_reg     <= '0;
            idx_reg       <= '0;
            step_reg      <= '0;
            cnt_reg       <= '0;
            clr_reg       <= '0;
            rsp_valid_reg <= 1'b0;
            slot_reg      <= '0;
            status_reg    <= phtqp_pkg::ST_DONE;
            coll_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            func_reg      <= func_next;
            plate_reg     <= plate_next;
            idx_reg       <= idx_next;
            step_reg      <= step_next;
            cnt_reg       <= cnt_next;
            clr_reg       <= clr_next;
            rsp_valid_reg <= rsp_valid_next;
            slot_reg      <= slot_next;
            status_reg    <= status_next;
            coll_reg      <= coll_next;
        end
    end

    // Plate memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (plate_we)
        begin
            plate_mem[idx_reg] <= plate_reg;
        end
        rd_plate_reg <= plate_mem[rd_addr];
    end

    // Occupancy memory: cleared by the pass after reset, then set and cleared per request.
    always_ff @(posedge clk)
    begin
        if (valid_we)
        begin
            valid_mem[valid_wr_addr] <= valid_wr_data;
        end
        rd_valid_reg <= valid_mem[rd_addr];
    end

    `PHTQP_ASSERT_IMP(a_cnt_range, state_reg == B_PROBE, cnt_reg < FULL_CNT, "probe count past table size")
    `PHTQP_ASSERT_IMP(a_idx_range, state_reg == B_PROBE, ({1'b0, idx_reg} < N_EXT) && ({1'b0, step_reg} < N_EXT), "probe slot or increment out of range")
    `PHTQP_ASSERT_IMP(a_clear_quiet, state_reg == B_CLEAR, !q_pop && !plate_we && !rsp_valid_reg, "request activity during clearing pass")
    `PHTQP_ASSERT_NXT(a_insert_resp, plate_we, (state_reg == B_IDLE) && rsp_valid_reg && (status_reg == phtqp_pkg::ST_DONE), "stored plate without a done response")

endmodule

>>> hdl/plate_hash_table_quadratic_probe.sv
// Top level of the plate hash table with quadratic probing.
// Depends on phtqp_pkg, phtqp_front, phtqp_queue and phtqp_back.

// Open-addressed table of TABLE_SIZE eight-byte plates. Each request inserts,
// searches for or removes one plate and yields exactly one response with the
// slot, a status and the number of occupied non-matching slots passed. After
// reset the occupancy memory is cleared one slot per cycle, and no request is
// taken until that pass ends. For each request the front end forms the letter
// and digit sums, then multiplies, and the residue unit then folds six sum bits
// per cycle, with the hand-off to the queue overlapping the next acceptance. The
// probe engine then launches the request and takes one probe per slot read,
// since the probe addresses are independent of the data and the slot memory
// returns one registered read per cycle; its work overlaps the front end
// through a queue of QUEUE_DEPTH entries, so a lightly loaded table is paced by
// the front end, and long probe chains set the request rate otherwise.
module plate_hash_table_quadratic_probe #(
    parameter int TABLE_SIZE  = 1031,
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               req_valid,
    output logic                               req_stall,
    input  logic [phtqp_pkg::FUNC_W-1:0]       func,
    input  logic [phtqp_pkg::PLATE_W-1:0]      plate,
    output logic                               rsp_valid,
    input  logic                               rsp_stall,
    output logic [phtqp_pkg::SLOT_W-1:0]       slot,
    output logic [phtqp_pkg::STATUS_W-1:0]     status,
    output logic [phtqp_pkg::COLL_W-1:0]       collisions
);

    localparam int IDX_W = $clog2(TABLE_SIZE);

    logic                 clearing;
    logic                 q_push;
    logic                 q_pop;
    phtqp_pkg::req_t      q_wr_req;
    phtqp_pkg::req_t      q_rd_req;
    logic [IDX_W-1:0]     q_wr_home;
    logic [IDX_W-1:0]     q_rd_home;
    phtqp_pkg::q_flags_t  q_flags;

    // Request intake and home slot computation.
    phtqp_front #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .func      (func),
        .plate     (plate),
        .clearing  (clearing),
        .q_flags   (q_flags),
        .q_push    (q_push),
        .q_req     (q_wr_req),
        .q_home    (q_wr_home)
    );

    // Hand-off queue between intake and probing.
    phtqp_queue #(
        .DEPTH  (QUEUE_DEPTH),
        .HOME_W (IDX_W)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_req  (q_wr_req),
        .wr_home (q_wr_home),
        .pop     (q_pop),
        .rd_req  (q_rd_req),
        .rd_home (q_rd_home),
        .flags   (q_flags)
    );

    // Probe engine with the slot memories and the response register.
    phtqp_back #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_flags    (q_flags),
        .q_req      (q_rd_req),
        .q_home     (q_rd_home),
        .q_pop      (q_pop),
        .clearing   (clearing),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .slot       (slot),
        .status     (status),
        .collisions (collisions)
    );

endmodule

>>> verif/tb_plate_hash_table_quadratic_probe.sv
// Self-checking testbench for the plate hash table with quadratic probing.
// Needs phtqp_pkg and the plate_hash_table_quadratic_probe RTL; nothing else.
// A directed table, then random traffic and a saturated probe chain, scored by a model or hand-written replies.
module tb_plate_hash_table_quadratic_probe;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_SIZE  = 1031;
    localparam int POOL_DEPTH  = 256;
    localparam int STALL_LIMIT = 10000;
    localparam int TAIL_CYCLES = 50;
    localparam int CHAIN_LEN   = 520;
    localparam int N_DIRECTED  = 24;

    // The block treats the spare operation code as a search.
    localparam logic [phtqp_pkg::FUNC_W-1:0] FN_UNUSED = 2'd3;

    // Expected contents of one reply.
    typedef struct {
        logic [phtqp_pkg::SLOT_W-1:0] slot;
        phtqp_pkg::status_t           status;
        logic [phtqp_pkg::COLL_W-1:0] coll;
    } reply_t;

    // One directed request; when known is set the reply is written out by hand.
    typedef struct packed {
        logic [phtqp_pkg::FUNC_W-1:0]  op;
        logic [phtqp_pkg::PLATE_W-1:0] key;
        logic                          known;
        logic [phtqp_pkg::SLOT_W-1:0]  slot;
        phtqp_pkg::status_t            status;
        logic [phtqp_pkg::COLL_W-1:0]  coll;
    } dir_row_t;

    logic                           clk        = 1'b0;
    logic                           rst_n      = 1'b0;
    logic                           req_valid  = 1'b0;
    logic                           req_stall;
    logic [phtqp_pkg::FUNC_W-1:0]   func       = '0;
    logic [phtqp_pkg::PLATE_W-1:0]  plate      = '0;
    logic                           rsp_valid;
    logic                           rsp_stall  = 1'b0;
    logic [phtqp_pkg::SLOT_W-1:0]   slot;
    logic [phtqp_pkg::STATUS_W-1:0] status;
    logic [phtqp_pkg::COLL_W-1:0]   collisions;

    // Model of the table contents.
    logic [phtqp_pkg::PLATE_W-1:0] stored_plate [TABLE_SIZE];
    bit                            occupied     [TABLE_SIZE];

    reply_t                        awaited_replies [$];
    logic [phtqp_pkg::PLATE_W-1:0] known_plates [$];

    // Home slot 0 is shared by plate zero and the two digit-shifted plates below.
    dir_row_t directed_rows [N_DIRECTED] = '{
        '{phtqp_pkg::FN_SEARCH, 64'h0,                   1'b1, 11'd0, phtqp_pkg::ST_ABSENT, 11'd0},
        '{phtqp_pkg::FN_SEARCH, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 11'd0, phtqp_pkg::ST_ABSENT, 11'd0},
        '{phtqp_pkg::FN_REMOVE, 64'h0,                   1'b1, 11'd0, phtqp_pkg::ST_ABSENT, 11'd0},
        '{FN_UNUSED,            64'h8000_0000_0000_0000, 1'b1, 11'd0, phtqp_pkg::ST_ABSENT, 11'd0},
        '{phtqp_pkg::FN_INSERT, 64'h0,                   1'b1, 11'd0, phtqp_pkg::ST_DONE,   11'd0},
        '{phtqp_pkg::FN_INSERT, 64'h0,                   1'b1, 11'd0, phtqp_pkg::ST_DONE,   11'd0},
        '{FN_UNUSED,            64'h0,                   1'b1, 11'd0, phtqp_pkg::ST_DONE,   11'd0},
        '{phtqp_pkg::FN_INSERT, 64'h0000_0000_0100_001F, 1'b1, 11'd1, phtqp_pkg::ST_DONE,   11'd1},
        '{phtqp_pkg::FN_INSERT, 64'h0000_0000_0200_003E, 1'b1, 11'd4, phtqp_pkg::ST_DONE,   11'd2},
        '{phtqp_pkg::FN_SEARCH, 64'h0000_0000_0200_003E, 1'b1, 11'd4, phtqp_pkg::ST_DONE,   11'd2},
        '{phtqp_pkg::FN_REMOVE, 64'h0000_0000_0100_001F, 1'b1, 11'd1, phtqp_pkg::ST_DONE,   11'd1},
        '{phtqp_pkg::FN_SEARCH, 64'h0000_0000_0200_003E, 1'b1, 11'd0, phtqp_pkg::ST_ABSENT, 11'd1},
        '{phtqp_pkg::FN_REMOVE, 64'h0000_0000_0100_001F, 1'b1, 11'd0, phtqp_pkg::ST_ABSENT, 11'd1},
        '{phtqp_pkg::FN_INSERT, 64'h0000_0000_0200_003E, 1'b1, 11'd1, phtqp_pkg::ST_DONE,   11'd1},
        '{phtqp_pkg::FN_REMOVE, 64'h0000_0000_0200_003E, 1'b1, 11'd1, phtqp_pkg::ST_DONE,   11'd1},
        '{phtqp_pkg::FN_REMOVE, 64'h0000_0000_0200_003E, 1'b1, 11'd0, phtqp_pkg::ST_ABSENT, 11'd1},
        '{phtqp_pkg::FN_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 11'd0, phtqp_pkg::ST_DONE,   11'd0},
        '{phtqp_pkg::FN_SEARCH, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 11'd0, phtqp_pkg::ST_DONE,   11'd0},
        '{phtqp_pkg::FN_INSERT, 64'h5555_5555_5555_5555, 1'b0, 11'd0, phtqp_pkg::ST_DONE,   11'd0},
        '{phtqp_pkg::FN_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 11'd0, phtqp_pkg::ST_DONE,   11'd0},
        '{phtqp_pkg::FN_REMOVE, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 11'd0, phtqp_pkg::ST_DONE,   11'd0},
        '{phtqp_pkg::FN_INSERT, 64'h8000_0000_0000_0000, 1'b0, 11'd0, phtqp_pkg::ST_DONE,   11'd0},
        '{phtqp_pkg::FN_INSERT, 64'h0000_0000_0000_0001, 1'b0, 11'd0, phtqp_pkg::ST_DONE,   11'd0},
        '{phtqp_pkg::FN_SEARCH, 64'h0,                   1'b1, 11'd0, phtqp_pkg::ST_DONE,   11'd0}
    };

    bit          send_gaps   = 1'b1;
    bit          sink_gaps   = 1'b1;
    int unsigned stall_left  = 0;
    int unsigned idle_cycles = 0;
    int unsigned mismatches  = 0;
    int unsigned items_sent  = 0;
    int unsigned replies_ok  = 0;
    int unsigned full_seen   = 0;
    int unsigned miss_seen   = 0;
    int unsigned longest_run = 0;

    plate_hash_table_quadratic_probe #(
        .TABLE_SIZE (TABLE_SIZE)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .func       (func),
        .plate      (plate),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .slot       (slot),
        .status     (status),
        .collisions (collisions)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Home slot: letters weighted base 26, scaled by 10000, plus the four digits.
    function automatic int unsigned plate_home(input logic [phtqp_pkg::PLATE_W-1:0] p);
        logic [63:0] letters;
        logic [63:0] total;
        letters = 64'(p[63:56]) * 64'd17576 + 64'(p[55:48]) * 64'd676
                + 64'(p[47:40]) * 64'd26 + 64'(p[39:32]);
        total = letters * 64'd10000 + 64'(p[31:24]) * 64'd1000
              + 64'(p[23:16]) * 64'd100 + 64'(p[15:8]) * 64'd10 + 64'(p[7:0]);
        return 32'(total % 64'(TABLE_SIZE));
    endfunction

    // Walks the quadratic probe sequence, updates the table and returns the reply.
    function automatic reply_t probe_table(input logic [phtqp_pkg::FUNC_W-1:0]  op,
                                           input logic [phtqp_pkg::PLATE_W-1:0] p);
        reply_t      r;
        int unsigned home;
        int unsigned idx;
        int unsigned t;
        bit          busy;
        bit          same;
        bit          hit;
        bit          stop;
        home = plate_home(p);
        r.slot = '0;
        t = 0;
        hit = 1'b0;
        stop = 1'b0;
        while (!stop && t < TABLE_SIZE)
        begin
            idx = (home + t * t) % TABLE_SIZE;
            busy = occupied[idx];
            same = busy && stored_plate[idx] == p;
            if (same || (op == phtqp_pkg::FN_INSERT && !busy))
            begin
                hit = 1'b1;
                stop = 1'b1;
                r.slot = phtqp_pkg::SLOT_W'(idx);
                if (op == phtqp_pkg::FN_INSERT)
                begin
                    stored_plate[idx] = p;
                    occupied[idx] = 1'b1;
                end
                else if (op == phtqp_pkg::FN_REMOVE)
                begin
                    occupied[idx] = 1'b0;
                end
            end
            else if (!busy)
            begin
                stop = 1'b1;
            end
            else
            begin
                t++;
            end
        end
        if (hit)
            r.status = phtqp_pkg::ST_DONE;
        else if (op == phtqp_pkg::FN_INSERT)
            r.status = phtqp_pkg::ST_FULL;
        else
            r.status = phtqp_pkg::ST_ABSENT;
        r.coll = t[phtqp_pkg::COLL_W-1:0];
        return r;
    endfunction

    // Random plate whose home slot is h; the last byte shifts the home linearly.
    function automatic logic [phtqp_pkg::PLATE_W-1:0] plate_at_home(input int unsigned h);
        logic [phtqp_pkg::PLATE_W-1:0] p;
        int unsigned                   need;
        do
        begin
            p = {$urandom, $urandom};
            p[7:0] = 8'd0;
            need = (h + TABLE_SIZE - plate_home(p)) % TABLE_SIZE;
        end
        while (need > 255);
        p[7:0] = need[7:0];
        return p;
    endfunction

    // Offers one item, waits for it to be taken and records the expected reply.
    task automatic issue_request(input logic [phtqp_pkg::FUNC_W-1:0]  op,
                                 input logic [phtqp_pkg::PLATE_W-1:0] p);
        if (send_gaps && $urandom_range(0, 4) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        req_valid <= 1'b1;
        func <= op;
        plate <= p;
        do
            @(posedge clk);
        while (req_stall !== 1'b0);
        awaited_replies.push_back(probe_table(op, p));
        items_sent++;
        if (op == phtqp_pkg::FN_INSERT)
        begin
            if (known_plates.size() < POOL_DEPTH)
                known_plates.push_back(p);
            else
                known_plates[$urandom_range(0, POOL_DEPTH - 1)] = p;
        end
    endtask

    // Holds the request side idle until every outstanding reply is back.
    task automatic drain_replies();
        req_valid <= 1'b0;
        while (awaited_replies.size() != 0)
            @(posedge clk);
    endtask

    // Random mix: plates already seen, fresh plates sharing their home, and noise.
    task automatic run_random(input int unsigned count, input int unsigned insert_pct,
                              input bit gaps_allowed);
        int unsigned                   n;
        int unsigned                   roll;
        logic [phtqp_pkg::FUNC_W-1:0]  op;
        logic [phtqp_pkg::PLATE_W-1:0] p;
        for (n = 0; n < count; n++)
        begin
            if (n % 64 == 0)
            begin
                send_gaps = gaps_allowed && ($urandom_range(0, 3) != 0);
                sink_gaps = gaps_allowed && ($urandom_range(0, 3) != 0);
            end
            roll = $urandom_range(0, 99);
            if (roll < insert_pct)
                op = phtqp_pkg::FN_INSERT;
            else if (roll >= 95)
                op = FN_UNUSED;
            else if (roll[0])
                op = phtqp_pkg::FN_SEARCH;
            else
                op = phtqp_pkg::FN_REMOVE;
            roll = $urandom_range(0, 99);
            if (known_plates.size() == 0 || roll < 25)
                p = {$urandom, $urandom};
            else if (roll < 45)
                p = plate_at_home(plate_home(
                        known_plates[$urandom_range(0, known_plates.size() - 1)]));
            else
                p = known_plates[$urandom_range(0, known_plates.size() - 1)];
            issue_request(op, p);
        end
    endtask

    // Reply scoreboard, reply-side stall bursts and the progress counter.
    always @(posedge clk)
    begin
        reply_t want;
        if (!rst_n)
        begin
            idle_cycles = 0;
            rsp_stall <= 1'b0;
        end
        else
        begin
            if ((req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall))
                idle_cycles = 0;
            else
                idle_cycles++;

            if (rsp_valid === 1'b1 && !rsp_stall)
            begin
                if (awaited_replies.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected reply: slot %0d status %0d collisions %0d",
                                 slot, status, collisions);
                end
                else
                begin
                    want = awaited_replies.pop_front();
                    replies_ok++;
                    if (want.status == phtqp_pkg::ST_FULL)
                        full_seen++;
                    if (want.status == phtqp_pkg::ST_ABSENT)
                        miss_seen++;
                    if (32'(want.coll) > longest_run)
                        longest_run = 32'(want.coll);
                    if (slot !== want.slot || status !== want.status
                        || collisions !== want.coll)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $write("Mismatch on reply %0d (expected/actual): ", replies_ok);
                            $display("slot %0d/%0d status %0d/%0d collisions %0d/%0d",
                                     want.slot, slot, want.status, status,
                                     want.coll, collisions);
                        end
                    end
                end
            end

            // Stall bursts on the reply side, each of random length.
            if (stall_left != 0)
            begin
                rsp_stall <= 1'b1;
                stall_left--;
            end
            else if (sink_gaps && $urandom_range(0, 5) == 0)
            begin
                rsp_stall <= 1'b1;
                stall_left = $urandom_range(0, 4);
            end
            else
            begin
                rsp_stall <= 1'b0;
            end
        end
    end

    // Ends the run if nothing moves for too long.
    initial
    begin
        wait (rst_n === 1'b1);
        while (idle_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("Timeout: no item moved for %0d cycles, %0d replies outstanding",
                 STALL_LIMIT, awaited_replies.size());
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        int unsigned                   i;
        int unsigned                   chain_home;
        logic [phtqp_pkg::PLATE_W-1:0] p;
        logic [phtqp_pkg::PLATE_W-1:0] chain_plates [$];

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed rows; a hand-written reply replaces the predicted one.
        foreach (directed_rows[k])
        begin
            issue_request(directed_rows[k].op, directed_rows[k].key);
            if (directed_rows[k].known)
                awaited_replies[awaited_replies.size() - 1] =
                    '{directed_rows[k].slot, directed_rows[k].status, directed_rows[k].coll};
        end

        // Light load with random plates and frequent repeats.
        run_random(800, 45, 1'b1);
        drain_replies();

        // Pile plates onto one home until its probe sequence has no free slot left.
        send_gaps = 1'b1;
        sink_gaps = 1'b1;
        chain_home = $urandom_range(0, TABLE_SIZE - 1);
        for (i = 0; i < CHAIN_LEN; i++)
        begin
            p = plate_at_home(chain_home);
            chain_plates.push_back(p);
            issue_request(phtqp_pkg::FN_INSERT, p);
        end
        for (i = 0; i < 3; i++)
            issue_request(phtqp_pkg::FN_INSERT, plate_at_home(chain_home));
        issue_request(phtqp_pkg::FN_SEARCH, plate_at_home(chain_home));
        issue_request(FN_UNUSED, plate_at_home(chain_home));
        issue_request(phtqp_pkg::FN_SEARCH, chain_plates[CHAIN_LEN - 1]);
        issue_request(phtqp_pkg::FN_REMOVE, chain_plates[CHAIN_LEN / 2]);
        issue_request(phtqp_pkg::FN_SEARCH, chain_plates[CHAIN_LEN - 1]);
        issue_request(phtqp_pkg::FN_REMOVE, plate_at_home(chain_home));
        issue_request(phtqp_pkg::FN_INSERT, chain_plates[CHAIN_LEN / 2]);

        // Heavy load, then a stretch at full rate with no gaps on either side.
        run_random(450, 35, 1'b1);
        run_random(200, 40, 1'b0);
        drain_replies();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d requests, checked %0d replies: %0d misses, %0d full-table inserts.",
                 items_sent, replies_ok, miss_seen, full_seen);
        $display("Longest probe run %0d collisions; home slot %0d was driven to saturation.",
                 longest_run, chain_home);
        if (mismatches == 0 && awaited_replies.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hdl
hdl/phtqp_pkg.sv
hdl/phtqp_front.sv
hdl/phtqp_queue.sv
hdl/phtqp_back.sv
hdl/plate_hash_table_quadratic_probe.sv
verif/tb_plate_hash_table_quadratic_probe.sv
